// File: rtl/core/page_framebuffer_draw_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame buffer draw engine
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH

// The expression must never hold.
`define PFDE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define PFDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// Types and constants shared by the page frame buffer draw engine modules.
// ----------------------------------------------------------------------------
package pfde_pkg;

  // Command codes carried in the input beat.
  typedef enum logic [1:0] {
    CMD_PLOT = 2'd0,
    CMD_RECT = 2'd1,
    CMD_FILL = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_PIX_RD = 3'd2,
    ST_PIX_WR = 3'd3,
    ST_SWEEP  = 3'd4,
    ST_READ   = 3'd5,
    ST_DONE   = 3'd6
  } state_t;

  // Width of the signed working coordinate (corner plus offset, mirrored).
  localparam int COORD_W = 13;
  // Width used to range-check a byte index against the store size.
  localparam int IDX_EXT_W = 13;

  // Mapped pixel: on screen flag and bit position within the page byte.
  typedef struct packed {
    logic       hit;
    logic [2:0] bit_sel;
  } pix_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } res_t;

endpackage

// File: rtl/core/pfde_ram.sv
// ----------------------------------------------------------------------------
// pfde_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: rtl/core/pfde_pixmap.sv
// ----------------------------------------------------------------------------
// pfde_pixmap
// Mirrors a pixel coordinate, clips it to the screen and maps it to a page
// byte address and bit position.
// ----------------------------------------------------------------------------
module pfde_pixmap #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int ADDR_W        = 10
) (
  input  logic signed [10:0]  x,
  input  logic signed [10:0]  y,
  input  logic [7:0]          col,
  input  logic [7:0]          row,
  output logic [ADDR_W-1:0]   addr,
  output pfde_pkg::pix_t      pix
);

  localparam logic signed [pfde_pkg::COORD_W-1:0] X_TOP =
    pfde_pkg::COORD_W'(SCREEN_WIDTH - 1);
  localparam logic signed [pfde_pkg::COORD_W-1:0] Y_TOP =
    pfde_pkg::COORD_W'(SCREEN_HEIGHT - 1);
  localparam logic signed [pfde_pkg::COORD_W-1:0] X_LIM =
    pfde_pkg::COORD_W'(SCREEN_WIDTH);
  localparam logic signed [pfde_pkg::COORD_W-1:0] Y_LIM =
    pfde_pkg::COORD_W'(SCREEN_HEIGHT);

  logic signed [pfde_pkg::COORD_W-1:0] sx;
  logic signed [pfde_pkg::COORD_W-1:0] sy;
  logic signed [pfde_pkg::COORD_W-1:0] mx;
  logic signed [pfde_pkg::COORD_W-1:0] my;

  // Offset the corner, then mirror both axes.
  always_comb begin
    sx = pfde_pkg::COORD_W'(x) + $signed({5'b0, col});
    sy = pfde_pkg::COORD_W'(y) + $signed({5'b0, row});
    mx = X_TOP - sx;
    my = Y_TOP - sy;
  end

  // Clip and map to page layout: eight rows per byte, pages of one screen width.
  always_comb begin
    pix.hit     = !mx[pfde_pkg::COORD_W-1] && (mx < X_LIM) &&
                  !my[pfde_pkg::COORD_W-1] && (my < Y_LIM);
    pix.bit_sel = my[2:0];
    addr        = ADDR_W'(mx[7:0]) + ADDR_W'(my[6:3]) * ADDR_W'(SCREEN_WIDTH);
  end

endmodule

// File: rtl/core/pfde_ctrl.sv
// ----------------------------------------------------------------------------
// pfde_ctrl
// Command sequencer: clearing pass, pixel read-modify-write, rectangle walk,
// fill sweep and byte readout against the frame store.
// ----------------------------------------------------------------------------
`include "page_framebuffer_draw_engine_unit_macros.svh"

module pfde_ctrl #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Command beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pfde_pkg::cmd_t        cmd,
  input  logic signed [10:0]    pos_x,
  input  logic signed [10:0]    pos_y,
  input  logic [7:0]            rect_width,
  input  logic [7:0]            rect_height,
  input  logic                  solid,
  input  logic                  pixel_on,
  input  logic [7:0]            fill_value,
  input  logic [9:0]            byte_index,
  // Result towards the output register
  output pfde_pkg::res_t        res,
  input  logic                  res_ready,
  // Frame store port
  output logic                  wr_en,
  output logic [$clog2(SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8))-1:0] wr_addr,
  output logic [7:0]            wr_data,
  output logic                  rd_en,
  output logic [$clog2(SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8))-1:0] rd_addr,
  input  logic [7:0]            rd_data
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  pfde_pkg::state_t state_r, state_nxt;

  logic signed [10:0] x_r, y_r;
  logic [7:0]         w_r, h_r, col_r, row_r;
  logic               solid_r, on_r;
  logic [7:0]         fill_r;
  logic [ADDR_W-1:0]  sweep_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [2:0]         bit_r;
  logic               rd_ok_r;
  logic [7:0]         res_data_r;

  logic [ADDR_W-1:0]  pix_addr;
  pfde_pkg::pix_t     pix;
  logic               col_last, row_last, border_row, walk_done;
  logic [7:0]         col_step;
  logic               sweep_last;
  logic               idx_ok;
  logic [pfde_pkg::IDX_EXT_W-1:0] idx_ext;
  logic [7:0]         bit_mask;

  // Coordinate mapping of the current walk position.
  pfde_pixmap #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_pixmap (
    .x    (x_r),
    .y    (y_r),
    .col  (col_r),
    .row  (row_r),
    .addr (pix_addr),
    .pix  (pix)
  );

  // Walk and sweep bookkeeping. Interior rows of an outline jump from the
  // first column straight to the last.
  always_comb begin
    col_last   = (col_r == w_r - 8'd1);
    row_last   = (row_r == h_r - 8'd1);
    border_row = (row_r == 8'd0) || row_last;
    walk_done  = col_last && row_last;
    col_step   = (solid_r || border_row || (col_r != 8'd0)) ? col_r + 8'd1 : w_r - 8'd1;
    sweep_last = (sweep_r == ADDR_W'(STORE_BYTES - 1));
    idx_ext    = pfde_pkg::IDX_EXT_W'(byte_index);
    idx_ok     = (idx_ext < pfde_pkg::IDX_EXT_W'(STORE_BYTES));
    bit_mask   = 8'd1 << bit_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfde_pkg::ST_CLEAR: begin
        if (sweep_last) state_nxt = pfde_pkg::ST_IDLE;
      end
      pfde_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            pfde_pkg::CMD_PLOT: state_nxt = pfde_pkg::ST_PIX_RD;
            pfde_pkg::CMD_RECT: begin
              if ((rect_width == 8'd0) || (rect_height == 8'd0)) begin
                state_nxt = pfde_pkg::ST_DONE;
              end else begin
                state_nxt = pfde_pkg::ST_PIX_RD;
              end
            end
            pfde_pkg::CMD_FILL: state_nxt = pfde_pkg::ST_SWEEP;
            pfde_pkg::CMD_READ: state_nxt = pfde_pkg::ST_READ;
            default:            state_nxt = pfde_pkg::ST_IDLE;
          endcase
        end
      end
      pfde_pkg::ST_PIX_RD: begin
        if (pix.hit) begin
          state_nxt = pfde_pkg::ST_PIX_WR;
        end else if (walk_done) begin
          state_nxt = pfde_pkg::ST_DONE;
        end
      end
      pfde_pkg::ST_PIX_WR: begin
        state_nxt = walk_done ? pfde_pkg::ST_DONE : pfde_pkg::ST_PIX_RD;
      end
      pfde_pkg::ST_SWEEP: begin
        if (sweep_last) state_nxt = pfde_pkg::ST_DONE;
      end
      pfde_pkg::ST_READ: state_nxt = pfde_pkg::ST_DONE;
      pfde_pkg::ST_DONE: begin
        if (res_ready) state_nxt = pfde_pkg::ST_IDLE;
      end
      default: state_nxt = pfde_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory port control, handshake and result.
  always_comb begin
    in_ready  = (state_r == pfde_pkg::ST_IDLE);
    rd_en     = ((state_r == pfde_pkg::ST_PIX_RD) && pix.hit) ||
                ((state_r == pfde_pkg::ST_IDLE) && in_valid && (cmd == pfde_pkg::CMD_READ));
    rd_addr   = (state_r == pfde_pkg::ST_IDLE) ? idx_ext[ADDR_W-1:0] : pix_addr;
    wr_en     = (state_r == pfde_pkg::ST_CLEAR) || (state_r == pfde_pkg::ST_SWEEP) ||
                (state_r == pfde_pkg::ST_PIX_WR);
    wr_addr   = (state_r == pfde_pkg::ST_PIX_WR) ? addr_r : sweep_r;
    unique case (state_r)
      pfde_pkg::ST_PIX_WR: wr_data = on_r ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
      pfde_pkg::ST_SWEEP:  wr_data = fill_r;
      default:             wr_data = 8'd0;
    endcase
    res.valid = (state_r == pfde_pkg::ST_DONE);
    res.data  = res_data_r;
  end

  // State register and sweep counter for the clearing pass and the fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfde_pkg::ST_CLEAR;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == pfde_pkg::ST_CLEAR) || (state_r == pfde_pkg::ST_SWEEP)) begin
        sweep_r <= sweep_r + ADDR_W'(1);
      end else if (state_r == pfde_pkg::ST_IDLE) begin
        sweep_r <= '0;
      end
    end
  end

  // Command capture, walk position and readout data.
  always_ff @(posedge clk) begin
    unique case (state_r)
      pfde_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_r        <= pos_x;
          y_r        <= pos_y;
          col_r      <= 8'd0;
          row_r      <= 8'd0;
          on_r       <= pixel_on;
          fill_r     <= fill_value;
          rd_ok_r    <= idx_ok;
          res_data_r <= 8'd0;
          if (cmd == pfde_pkg::CMD_PLOT) begin
            w_r     <= 8'd1;
            h_r     <= 8'd1;
            solid_r <= 1'b1;
          end else begin
            w_r     <= rect_width;
            h_r     <= rect_height;
            solid_r <= solid;
          end
        end
      end
      pfde_pkg::ST_PIX_RD: begin
        if (pix.hit) begin
          addr_r <= pix_addr;
          bit_r  <= pix.bit_sel;
        end else if (col_last) begin
          col_r <= 8'd0;
          row_r <= row_r + 8'd1;
        end else begin
          col_r <= col_step;
        end
      end
      pfde_pkg::ST_PIX_WR: begin
        if (col_last) begin
          col_r <= 8'd0;
          row_r <= row_r + 8'd1;
        end else begin
          col_r <= col_step;
        end
      end
      pfde_pkg::ST_READ: begin
        res_data_r <= rd_ok_r ? rd_data : 8'd0;
      end
      default: begin
      end
    endcase
  end

  // Checks on memory access ordering and result hand-off.
  `PFDE_ASSERT_NEVER(a_rw_clash, wr_en && rd_en, "store read and written in one cycle")
  `PFDE_ASSERT_IMP(a_wr_follows_rd, state_r == pfde_pkg::ST_PIX_WR, $past(rd_en) && ($past(rd_addr) == addr_r), "pixel write without matching read")
  `PFDE_ASSERT_NEXT(a_res_held, res.valid && !res_ready, res.valid && $stable(res.data), "pending result dropped or changed")
  `PFDE_ASSERT_NEXT(a_read_done, state_r == pfde_pkg::ST_READ, res.valid, "readout not presented")

endmodule

// File: rtl/core/page_framebuffer_draw_engine_unit.sv
// A plot or rectangle reads and then writes back each pixel it draws and skips each clipped
// pixel; a read fetches its byte from the store. Each then presents its result.
// A fill sweeps the store at one byte a cycle, writing every byte, then presents its result.
// One command at a time; the next beat is taken while a result waits in the output register.
// After reset a clearing pass writes zero to all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) store
// bytes; no command is accepted until it ends.
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit
// Monochrome page-layout frame buffer with pixel, rectangle, fill and byte
// readout commands, held in one synchronous memory.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [10:0] pos_x, [21:11] pos_y, [29:22] rect_width, [37:30] rect_height,
  // [38] solid, [39] pixel_on, [47:40] fill_value, [57:48] byte_index, [63:58] zero
  input  logic [63:0] in_tdata,
  // [1:0] cmd
  input  logic [1:0]  in_tuser,
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_byte
  output logic [7:0]  out_tdata
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  pfde_pkg::res_t    res;
  logic              res_ready;
  logic              out_valid_r;
  logic [7:0]        out_data_r;

  // Frame store.
  pfde_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Command sequencer.
  pfde_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cmd         (pfde_pkg::cmd_t'(in_tuser)),
    .pos_x       ($signed(in_tdata[10:0])),
    .pos_y       ($signed(in_tdata[21:11])),
    .rect_width  (in_tdata[29:22]),
    .rect_height (in_tdata[37:30]),
    .solid       (in_tdata[38]),
    .pixel_on    (in_tdata[39]),
    .fill_value  (in_tdata[47:40]),
    .byte_index  (in_tdata[57:48]),
    .res         (res),
    .res_ready   (res_ready),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Output register: takes a new result when empty or when its beat leaves.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data_r <= res.data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame buffer draw engine testbench
// Drives plot, rectangle, fill and read commands into the command channel, first
// from a short directed table and then at random, and checks every result beat
// against the table's byte where known, else a local page-layout model of the frame store.
// ----------------------------------------------------------------------------
module tb;
  import pfde_pkg::*;

  localparam int SCR_W       = 128;
  localparam int SCR_H       = 64;
  localparam int STORE_BYTES = SCR_W * ((SCR_H + 7) / 8);
  localparam int RANDOM_CMDS = 1525;

  // One command as carried by a command beat.
  typedef struct packed {
    cmd_t               op;
    logic signed [10:0] px;
    logic signed [10:0] py;
    logic [7:0]         rw;
    logic [7:0]         rh;
    logic               solid;
    logic               pix_on;
    logic [7:0]         fill;
    logic [9:0]         idx;
  } draw_cmd_t;

  // Directed row: a command and, where obvious, the byte it must return.
  typedef struct packed {
    draw_cmd_t  c;
    logic       has_known;
    logic [7:0] known_byte;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  // Local copy of the frame store and the bytes still owed by the block.
  logic [7:0] frame_mem [STORE_BYTES];
  logic [7:0] readout_q [$];
  int         last_touched;
  int         fault_count;
  dir_row_t   dir_tab [$];

  page_framebuffer_draw_engine_unit #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Prints one line per mismatch and counts it.
  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t: %s: read_byte got %02h, wanted %02h", $time, what, got, want);
    fault_count++;
  endtask

  // Sets or clears one pixel after mirroring both coordinates; pixels that
  // land off the screen are dropped.
  function automatic void mark_dot(input int x, input int y, input logic on);
    int mx;
    int my;
    int addr;
    mx = SCR_W - 1 - x;
    my = SCR_H - 1 - y;
    if (mx < 0 || mx >= SCR_W || my < 0 || my >= SCR_H) return;
    addr = mx + (my / 8) * SCR_W;
    if (addr >= STORE_BYTES) return;
    frame_mem[addr][my % 8] = on;
    last_touched = addr;
  endfunction

  // Applies one command to the local store and returns the byte it reads.
  function automatic logic [7:0] predict_readout(input draw_cmd_t c);
    logic [7:0] rd;
    int x0;
    int y0;
    int w;
    int h;
    rd = 8'h00;
    x0 = int'($signed(c.px));
    y0 = int'($signed(c.py));
    w  = int'(c.rw);
    h  = int'(c.rh);
    case (c.op)
      CMD_PLOT: mark_dot(x0, y0, c.pix_on);
      CMD_RECT: begin
        for (int r = 0; r < h; r++)
          for (int k = 0; k < w; k++)
            if (c.solid || r == 0 || r == h - 1 || k == 0 || k == w - 1)
              mark_dot(x0 + k, y0 + r, c.pix_on);
      end
      CMD_FILL: foreach (frame_mem[a]) frame_mem[a] = c.fill;
      CMD_READ: if (int'(c.idx) < STORE_BYTES) rd = frame_mem[c.idx];
    endcase
    return rd;
  endfunction

  function automatic dir_row_t mk_row(input cmd_t op, input int x, input int y,
                                      input int w, input int h, input logic solid,
                                      input logic on, input int fv, input int idx,
                                      input logic has_known, input int known_byte);
    dir_row_t row;
    row.c.op        = op;
    row.c.px        = 11'(x);
    row.c.py        = 11'(y);
    row.c.rw        = 8'(w);
    row.c.rh        = 8'(h);
    row.c.solid     = solid;
    row.c.pix_on    = on;
    row.c.fill      = 8'(fv);
    row.c.idx       = 10'(idx);
    row.has_known   = has_known;
    row.known_byte  = 8'(known_byte);
    return row;
  endfunction

  // Coordinate mostly on screen, sometimes just off an edge, sometimes anywhere.
  function automatic logic [10:0] pick_coord(input int span);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 11'($urandom_range(0, span - 1));
    if (r == 8) return 11'(int'($urandom_range(0, span + 7)) - 4);
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int sel;
    int shape;
    sel      = $urandom_range(0, 99);
    c.px     = pick_coord(SCR_W);
    c.py     = pick_coord(SCR_H);
    c.solid  = 1'($urandom_range(0, 1));
    c.pix_on = ($urandom_range(0, 9) < 7);
    c.fill   = 8'($urandom_range(0, 255));
    c.idx    = ($urandom_range(0, 1) == 1) ? 10'(last_touched) : 10'($urandom_range(0, 1023));
    // Mostly small rectangles; long thin ones reach the high size bits cheaply.
    shape = $urandom_range(0, 199);
    if (shape == 0) begin
      c.rw = 8'($urandom_range(0, 255));
      c.rh = 8'($urandom_range(0, 255));
    end else if (shape < 140) begin
      c.rw = 8'($urandom_range(0, 15));
      c.rh = 8'($urandom_range(0, 15));
    end else if (shape < 170) begin
      c.rw = 8'($urandom_range(0, 255));
      c.rh = 8'($urandom_range(0, 3));
    end else begin
      c.rw = 8'($urandom_range(0, 3));
      c.rh = 8'($urandom_range(0, 255));
    end
    if (sel < 40)      c.op = CMD_PLOT;
    else if (sel < 60) c.op = CMD_RECT;
    else if (sel < 63) c.op = CMD_FILL;
    else               c.op = CMD_READ;
    return c;
  endfunction

  // Sender: idles for a drawn number of cycles, presents the beat at the
  // falling edge and holds it until accepted, then records the owed byte.
  bit send_calm;

  task automatic send_cmd(input draw_cmd_t c, input logic has_known,
                          input logic [7:0] known_byte);
    int gap;
    logic [7:0] pred;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {6'd0, c.idx, c.fill, c.pix_on, c.solid, c.rh, c.rw, c.py, c.px};
    in_tuser  = c.op;
    do @(posedge clk); while (!in_tready);
    pred = predict_readout(c);
    readout_q.push_back(has_known ? known_byte : pred);
  endtask

  // Receiver: stalls for a drawn number of cycles per beat, then takes the
  // next result beat and checks it against the oldest owed byte.
  initial begin
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (taken % 48 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      if (readout_q.size() == 0) begin
        note_mismatch("result beat with nothing owed", out_tdata, 8'h00);
      end else begin
        logic [7:0] want;
        want = readout_q.pop_front();
        if (out_tdata !== want) note_mismatch("result beat", out_tdata, want);
      end
    end
  end

  // Main sequence: reset, directed table, random commands, drain.
  initial begin
    fault_count  = 0;
    last_touched = 0;
    send_calm    = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_PLOT;
    foreach (frame_mem[a]) frame_mem[a] = 8'h00;

    // Store is clear after reset; corners are hit through the mirroring.
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_PLOT, 127, 63, 0, 0, 0, 1, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h01));
    dir_tab.push_back(mk_row(CMD_PLOT, 0, 0, 0, 0, 0, 1, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h80));
    // Off-screen plots are clipped and leave the store alone.
    dir_tab.push_back(mk_row(CMD_PLOT, 128, 5, 0, 0, 0, 1, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_PLOT, -1024, 1023, 0, 0, 0, 1, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_PLOT, 1023, -1024, 0, 0, 0, 1, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_PLOT, -1, 64, 0, 0, 0, 1, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_PLOT, 127, 63, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    // Fill, then clear a single pixel out of the full store.
    dir_tab.push_back(mk_row(CMD_FILL, 0, 0, 0, 0, 0, 0, 8'hFF, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 512, 1, 8'hFF));
    dir_tab.push_back(mk_row(CMD_PLOT, 64, 32, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 447, 1, 8'h7F));
    dir_tab.push_back(mk_row(CMD_FILL, 0, 0, 0, 0, 0, 0, 8'hA5, 0, 1, 8'h00));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'hA5));
    dir_tab.push_back(mk_row(CMD_FILL, 0, 0, 0, 0, 0, 0, 8'h00, 0, 1, 8'h00));
    // Rectangles: outline, largest solid, zero width, single pixel, one row.
    dir_tab.push_back(mk_row(CMD_RECT, 100, 40, 8, 8, 0, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 283, 0, 0));
    dir_tab.push_back(mk_row(CMD_RECT, -64, -100, 255, 255, 1, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(CMD_RECT, 10, 10, 0, 5, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(CMD_RECT, 5, 5, 1, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(CMD_RECT, 20, 3, 30, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1000, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].has_known, dir_tab[i].known_byte);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % 48 == 0) send_calm = ($urandom_range(0, 3) == 0);
      // Once, hold off until the block has returned everything owed.
      if (i == RANDOM_CMDS / 2) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        while (readout_q.size() != 0) @(posedge clk);
      end
      send_cmd(random_cmd(), 1'b0, 8'h00);
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("page_framebuffer_draw_engine_unit: match");
    end else begin
      $display("page_framebuffer_draw_engine_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, including the clearing pass.
  initial begin
    #40_000_000;
    $display("page_framebuffer_draw_engine_unit: mismatch");
    $finish;
  end

endmodule
